// File: rtl/core/fixed_point_17_14_alu_assert.svh
// ----------------------------------------------------------------------------
// fixed_point_17_14_alu_assert
// Assertion macros for the fixed-point ALU, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_17_14_ALU_ASSERT_SVH
`define FIXED_POINT_17_14_ALU_ASSERT_SVH
`ifndef SYNTHESIS
`define FPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and opcodes of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;
  localparam int FRACTION_BITS_DEF = 14;
  localparam int DataW = 32;
  localparam int DivW = 64;

  localparam logic [3:0] OP_MUL = 4'd0;
  localparam logic [3:0] OP_DIV = 4'd1;
  localparam logic [3:0] OP_ADD = 4'd2;
  localparam logic [3:0] OP_SUB = 4'd3;
  localparam logic [3:0] OP_FXDIV = 4'd4;
  localparam logic [3:0] OP_FXMUL = 4'd5;
  localparam logic [3:0] OP_INT2FX = 4'd6;
  localparam logic [3:0] OP_FX2INT = 4'd7;
  localparam logic [3:0] OP_FXADDI = 4'd8;
  localparam logic [3:0] OP_ROUND = 4'd9;

  // Classified word between the front and back parts.
  typedef struct packed {
    logic        is_div;   // goes through the divider
    logic        is_mul;   // goes through the multiplier
    logic        dz;       // zero divisor
    logic        shr;      // multiply result shifted right by F
    logic [DivW-1:0] num;  // signed dividend or precomputed result
    logic [DataW-1:0] opa;
    logic [DataW-1:0] opb;
  } cmd_t;
endpackage

// File: rtl/core/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Decodes one word per cycle and prepares operands for the back part.
// ----------------------------------------------------------------------------
module fpa_front #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic [3:0]               mode,
  input  logic signed [31:0]       operand_a,
  input  logic signed [31:0]       operand_b,
  output fpa_pkg::cmd_t            cmd
);
  localparam logic signed [63:0] Half = 64'sd1 <<< (FRACTION_BITS - 1);
  localparam logic signed [63:0] Mask = (64'sd1 <<< FRACTION_BITS) - 64'sd1;
  logic signed [63:0] a_x, b_x, b_sh;

  always_comb begin
    a_x = 64'(operand_a);
    b_x = 64'(operand_b);
    b_sh = b_x <<< FRACTION_BITS;
    cmd = '0;
    cmd.opa = operand_a;
    cmd.opb = operand_b;
    unique case (mode)
      fpa_pkg::OP_MUL: cmd.is_mul = 1'b1;
      fpa_pkg::OP_FXMUL: begin
        cmd.is_mul = 1'b1;
        cmd.shr = 1'b1;
      end
      fpa_pkg::OP_DIV: begin
        cmd.is_div = 1'b1;
        cmd.dz = (operand_b == '0);
        cmd.num = a_x;
      end
      fpa_pkg::OP_FXDIV: begin
        cmd.is_div = 1'b1;
        cmd.dz = (operand_b == '0);
        cmd.num = a_x <<< FRACTION_BITS;
      end
      fpa_pkg::OP_ADD: cmd.num = a_x + b_x;
      fpa_pkg::OP_SUB: cmd.num = a_x - b_x;
      fpa_pkg::OP_INT2FX: cmd.num = b_sh;
      fpa_pkg::OP_FXADDI: cmd.num = a_x + b_sh;
      // Division by 2^F truncates toward zero, so a negative value is biased
      // up by 2^F - 1 before the arithmetic shift.
      fpa_pkg::OP_FX2INT: cmd.num = (a_x + (a_x[63] ? Mask : 64'sd0)) >>> FRACTION_BITS;
      fpa_pkg::OP_ROUND: begin
        cmd.num = (operand_a <= 0) ? (a_x - Half + Mask) >>> FRACTION_BITS
                                   : (a_x + Half) >>> FRACTION_BITS;
      end
      default: cmd.num = '0;
    endcase
  end
endmodule

// File: rtl/core/fpa_fifo.sv
// ----------------------------------------------------------------------------
// fpa_fifo
// Small synchronous queue of classified or finished words.
// ----------------------------------------------------------------------------
module fpa_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = $clog2(DEPTH);
  logic [W-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [$clog2(DEPTH+1)-1:0] cnt_r;
  logic do_push, do_pop;

  assign full = (cnt_r == ($clog2(DEPTH+1))'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout = mem_r[rp_r];
  assign count = cnt_r;
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
    end
  end
endmodule

// File: rtl/core/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// Execution pipeline: a pipelined multiplier and a radix-2 pipelined divider
// of 64 stages, all words moving in lockstep.
// ----------------------------------------------------------------------------
`include "fixed_point_17_14_alu_assert.svh"
module fpa_back #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  fpa_pkg::cmd_t cmd,
  output logic          out_vld,
  output logic [31:0]   value,
  output logic          dz
);
  localparam int N = 64;
  localparam int S = N + 2;
  localparam logic signed [63:0] RndAdj = (64'sd1 <<< FRACTION_BITS) - 64'sd1;

  // stage 0: multiply low/high partial products; stage 1: combine.
  logic [S-1:0] vld_r;
  logic [S-1:0] isdiv_r, ismul_r, dz_r, shr_r, neg_r;
  logic [63:0] rem_r [S];
  logic [63:0] quo_r [S];
  logic [63:0] dvs_r [S];
  logic signed [47:0] pl_r;
  logic signed [47:0] ph_r;
  logic signed [63:0] prod;
  logic signed [63:0] prod_sh;
  logic [63:0] num_abs;
  logic [63:0] res;

  assign prod = 64'(ph_r) * 64'sd65536 + 64'(pl_r);
  // Truncating division of the product by 2^F.
  assign prod_sh = (prod + (prod[63] ? RndAdj : 64'sd0)) >>> FRACTION_BITS;
  assign num_abs = cmd.num[63] ? (~cmd.num + 64'd1) : cmd.num;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[S-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // multiply a by b split into 16-bit halves of b
      pl_r <= 48'(signed'(cmd.opa)) * 48'(signed'({1'b0, cmd.opb[15:0]}));
      ph_r <= 48'(signed'(cmd.opa)) * 48'(signed'(cmd.opb[31:16]));
      isdiv_r[0] <= cmd.is_div;
      ismul_r[0] <= cmd.is_mul;
      dz_r[0] <= cmd.dz;
      shr_r[0] <= cmd.shr;
      neg_r[0] <= cmd.num[63] ^ cmd.opb[31];
      rem_r[0] <= cmd.num;
      quo_r[0] <= num_abs;
      dvs_r[0] <= cmd.opb[31] ? -(64'(signed'(cmd.opb))) : 64'(cmd.opb);
      // stage 1: product lands in rem, divider state begins
      isdiv_r[1] <= isdiv_r[0];
      ismul_r[1] <= ismul_r[0];
      dz_r[1] <= dz_r[0];
      shr_r[1] <= shr_r[0];
      neg_r[1] <= neg_r[0];
      rem_r[1] <= ismul_r[0] ? (shr_r[0] ? prod_sh : prod)
                             : (isdiv_r[0] ? 64'd0 : rem_r[0]);
      quo_r[1] <= quo_r[0];
      dvs_r[1] <= dvs_r[0];
      for (int i = 2; i < S; i++) begin
        logic [64:0] tr;
        tr = {rem_r[i-1], quo_r[i-1][63]};
        isdiv_r[i] <= isdiv_r[i-1];
        ismul_r[i] <= ismul_r[i-1];
        dz_r[i] <= dz_r[i-1];
        shr_r[i] <= shr_r[i-1];
        neg_r[i] <= neg_r[i-1];
        dvs_r[i] <= dvs_r[i-1];
        if (isdiv_r[i-1]) begin
          if (tr >= {1'b0, dvs_r[i-1]} && dvs_r[i-1] != '0) begin
            tr = tr - {1'b0, dvs_r[i-1]};
            quo_r[i] <= {quo_r[i-1][62:0], 1'b1};
          end else begin
            quo_r[i] <= {quo_r[i-1][62:0], 1'b0};
          end
          rem_r[i] <= tr[63:0];
        end else begin
          quo_r[i] <= quo_r[i-1];
          rem_r[i] <= rem_r[i-1];
        end
      end
    end
  end

  always_comb begin
    if (!isdiv_r[S-1]) res = rem_r[S-1];
    else if (dz_r[S-1]) res = '0;
    else res = neg_r[S-1] ? (~quo_r[S-1] + 64'd1) : quo_r[S-1];
  end

  assign out_vld = vld_r[S-1];
  assign value = res[31:0];
  assign dz = dz_r[S-1] && isdiv_r[S-1];

  `FPA_ASSERT_IMP(a_dz_zero, clk, rst_n, out_vld && dz, value == '0)
  `FPA_ASSERT_NXT(a_hold, clk, rst_n, !adv, vld_r == $past(vld_r))
  `FPA_ASSERT_IMP(a_dz_div, clk, rst_n, out_vld && dz, isdiv_r[S-1])
endmodule

// File: rtl/core/fixed_point_17_14_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_17_14_alu
// 32-bit signed fixed-point ALU with a decoupled decode front and back.
// ----------------------------------------------------------------------------
// Channel | Ports                                   | Handshake
// input   | in_mode, in_operand_a, in_operand_b      | push / full
// result  | out_value, out_divide_by_zero            | empty / pop
//
// One word is accepted per cycle while full is low; a result reaches the output
// ports after its word passes through the command queue, each of the 66 back
// stages (two multiplier stages, 64 divider stages) and the result queue.
// The back pipeline advances only while the result queue has room for one
// more word, so a stalled pop eventually raises full. Reset is synchronous
// and clears all control state.
`include "fixed_point_17_14_alu_assert.svh"
module fixed_point_17_14_alu #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [3:0]         in_mode,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_value,
  output logic               out_divide_by_zero
);
  localparam int CW = $bits(fpa_pkg::cmd_t);
  localparam int RD = 4;
  fpa_pkg::cmd_t cmd, cq;
  logic [CW-1:0] cq_bits;
  logic cfull, cempty, bvld, bdz, rfull, adv, take;
  logic [31:0] bval;
  logic [32:0] rout;
  logic [$clog2(3)-1:0] ccnt;
  logic [$clog2(RD+1)-1:0] rcnt;

  fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .mode(in_mode), .operand_a(in_operand_a), .operand_b(in_operand_b), .cmd(cmd));

  fpa_fifo #(.W(CW), .DEPTH(2)) u_cq (
    .clk(clk), .rst_n(rst_n), .push(push), .din(cmd), .full(cfull),
    .pop(take), .dout(cq_bits), .empty(cempty), .count(ccnt));
  assign cq = fpa_pkg::cmd_t'(cq_bits);

  // Advance when the result queue can absorb an emerging word.
  assign adv = !rfull;
  assign take = adv && !cempty;

  fpa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(take), .cmd(cq),
    .out_vld(bvld), .value(bval), .dz(bdz));

  fpa_fifo #(.W(33), .DEPTH(RD)) u_rq (
    .clk(clk), .rst_n(rst_n), .push(bvld && adv), .din({bdz, bval}), .full(rfull),
    .pop(pop), .dout(rout), .empty(empty), .count(rcnt));

  assign full = cfull;
  assign out_value = rout[31:0];
  assign out_divide_by_zero = rout[32];

  `FPA_ASSERT_IMP(a_no_drop, clk, rst_n, bvld && adv, !rfull)
  `FPA_ASSERT_IMP(a_rcnt, clk, rst_n, 1'b1, rcnt <= ($clog2(RD+1))'(RD))
  `FPA_ASSERT_IMP(a_ccnt, clk, rst_n, 1'b1, ccnt <= 2)
endmodule
